// File: design/gppa_pkg.sv
// Shared types and constants for the grouped particle pool ager.
`timescale 1ns / 1ps
`default_nettype none

package gppa_pkg;

  localparam int LINK_W = 7;
  localparam logic [LINK_W-1:0] NULL_LINK = 7'h7F;
  localparam int AGE_W = 32;
  localparam int PROD_W = 64;
  localparam int DCNT_W = 6;
  localparam int SLOT_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    RES_DONE   = 2'd0,
    RES_PAUSED = 2'd1,
    RES_FULL   = 2'd2
  } res_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_ADD_RD,
    S_ADD_WR,
    S_GRP,
    S_CHK,
    S_RD,
    S_A1,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_UPD,
    S_UNLINK,
    S_DN_OK,
    S_DN_PAUSED,
    S_DN_FULL
  } state_e;

  typedef struct packed {
    logic latch;
    logic rd_free;
    logic add_wr;
    logic grp_load;
    logic grp_next;
    logic ent_a1;
    logic ent_mul;
    logic div_start;
    logic ent_upd;
    logic ent_unlink;
    logic res_load;
    res_e res_status;
  } cmd_t;

  typedef struct packed {
    logic paused;
    logic is_tick;
    logic free_ok;
    logic cur_link;
    logic last_grp;
    logic div_done;
    logic expired;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: design/gppa_in_if.sv
// Input channel: one add or tick transaction.
`timescale 1ns / 1ps
`default_nettype none

interface gppa_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  group;
  logic [31:0] lifespan;
  logic [31:0] time_step;

  modport source(output valid, action, group, lifespan, time_step, input ready);
  modport sink(input valid, action, group, lifespan, time_step, output ready);
endinterface

`default_nettype wire

// File: design/gppa_out_if.sv
// Output channel: one result transaction per input transaction.
`timescale 1ns / 1ps
`default_nettype none

interface gppa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] slot;
  logic [6:0] expired_count;

  modport source(output valid, status, slot, expired_count, input ready);
  modport sink(input valid, status, slot, expired_count, output ready);
endinterface

`default_nettype wire

// File: design/grouped_particle_pool_ager.sv
// A tick walks every group list, ages each live entry and unlinks expired ones;
// the 64-step restoring divider of the age-ratio term sets the per-entry cost.
// One transaction is worked at a time; the next is taken while a result waits.
// Reset is asynchronous active low; no clearing pass, link memory entries read
// as their reset value until first written.
`timescale 1ns / 1ps
`default_nettype none

module grouped_particle_pool_ager
  import gppa_pkg::*;
#(
  parameter int POOL_SIZE   = 64,
  parameter int GROUP_COUNT = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  gppa_in_if.sink     in_i,
  gppa_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  gppa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gppa_datapath #(
    .POOL_SIZE   (POOL_SIZE),
    .GROUP_COUNT (GROUP_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (in_i.action),
    .group_i      (in_i.group),
    .lifespan_i   (in_i.lifespan),
    .time_step_i  (in_i.time_step),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_slot_o   (out_o.slot),
    .out_count_o  (out_o.expired_count)
  );

endmodule

`default_nettype wire

// File: design/gppa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gppa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/gppa_div.sv
// Restoring divider, one quotient bit per cycle, with a quotient overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module gppa_div
  import gppa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] dividend_i,
  input  wire logic [AGE_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic [AGE_W-1:0]       quotient_o,
  output logic                   ovf_o
);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [PROD_W-1:0] dvd_q;
  logic [AGE_W-1:0]  dvs_q, rem_q, quo_q;
  logic              ovf_q;
  logic [AGE_W:0]    shifted, diff;
  logic              ge;

  assign shifted = {rem_q, dvd_q[PROD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
      rem_q <= ge ? diff[AGE_W-1:0] : shifted[AGE_W-1:0];
      quo_q <= {quo_q[AGE_W-2:0], ge};
      // Any quotient bit pushed past 32 bits means the quotient saturates.
      ovf_q <= ovf_q | quo_q[AGE_W-1];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign ovf_o      = ovf_q;

endmodule

`default_nettype wire

// File: design/gppa_datapath.sv
// Datapath: pool memories, free and group list heads, aging arithmetic, result register.
`timescale 1ns / 1ps
`default_nettype none

module gppa_datapath
  import gppa_pkg::*;
#(
  parameter int POOL_SIZE   = 64,
  parameter int GROUP_COUNT = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              action_i,
  input  wire logic [1:0]        group_i,
  input  wire logic [AGE_W-1:0]  lifespan_i,
  input  wire logic [AGE_W-1:0]  time_step_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             out_status_o,
  output logic [SLOT_W-1:0]      out_slot_o,
  output logic [CNT_W-1:0]       out_count_o
);

  localparam int PA = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  function automatic logic [GW-1:0] grp_wrap(input logic [1:0] g);
    logic [4:0] v;
    v = {3'b000, g};
    for (int k = 0; k < 3; k++) begin
      if (v >= 5'(GROUP_COUNT)) begin
        v = v - 5'(GROUP_COUNT);
      end
    end
    return v[GW-1:0];
  endfunction

  logic                  paused_q, tick_q;
  logic [GW-1:0]         g_q;
  logic [AGE_W-1:0]      life_in_q, dt_q, a1_q, lim_q;
  logic [LINK_W-1:0]     head_q [GROUP_COUNT];
  logic [LINK_W-1:0]     free_head_q, cur_q, prev_q, nx_q;
  logic [PROD_W-1:0]     p_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;
  res_e                  out_status_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [CNT_W-1:0]      out_count_q;

  logic [POOL_SIZE-1:0]  nvalid_q;
  logic                  rvalid_q;
  logic [PA-1:0]         raddr_q;

  logic [PA-1:0]         n_raddr, n_waddr, a_waddr;
  logic                  n_we, a_we;
  logic [LINK_W-1:0]     n_wdata, n_rdata, next_rd;
  logic [AGE_W-1:0]      a_wdata, age_rd, life_rd;
  logic [AGE_W:0]        a1_sum;
  logic [AGE_W+2:0]      res_sum;
  logic [AGE_W-1:0]      age_new, quo;
  logic                  ovf, div_done, expired, prev_link, out_free;

  // Never-written link entries read as their reset value: index plus one, last null.
  assign next_rd = rvalid_q ? n_rdata :
                   (raddr_q == PA'(POOL_SIZE - 1)) ? NULL_LINK :
                   LINK_W'(raddr_q) + LINK_W'(1);

  assign n_raddr   = cmd_i.rd_free ? free_head_q[PA-1:0] : cur_q[PA-1:0];
  assign prev_link = prev_q < LINK_W'(POOL_SIZE);

  assign a1_sum  = {1'b0, age_rd} + {1'b0, dt_q};
  assign res_sum = {3'b000, a1_q} + {2'b00, quo, 1'b0} + {3'b000, quo};

  always_comb begin
    if (lim_q == '0) begin
      age_new = (dt_q != '0) ? '1 : a1_q;
    end else if (ovf || (res_sum[AGE_W+2:AGE_W] != 3'b000)) begin
      age_new = '1;
    end else begin
      age_new = res_sum[AGE_W-1:0];
    end
  end

  assign expired = age_new > lim_q;

  always_comb begin
    n_we    = 1'b0;
    n_waddr = free_head_q[PA-1:0];
    n_wdata = head_q[g_q];
    a_we    = 1'b0;
    a_waddr = free_head_q[PA-1:0];
    a_wdata = '0;
    if (cmd_i.add_wr) begin
      n_we = 1'b1;
      a_we = 1'b1;
    end else if (cmd_i.ent_upd) begin
      a_we    = 1'b1;
      a_waddr = cur_q[PA-1:0];
      a_wdata = age_new;
      if (expired) begin
        n_we    = 1'b1;
        n_waddr = cur_q[PA-1:0];
        n_wdata = free_head_q;
      end
    end else if (cmd_i.ent_unlink && prev_link) begin
      n_we    = 1'b1;
      n_waddr = prev_q[PA-1:0];
      n_wdata = nx_q;
    end
  end

  gppa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  gppa_ram #(.WIDTH(AGE_W), .DEPTH(POOL_SIZE)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (cur_q[PA-1:0]),
    .rdata_o (age_rd)
  );

  gppa_ram #(.WIDTH(AGE_W), .DEPTH(POOL_SIZE)) u_life_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_wr),
    .waddr_i (free_head_q[PA-1:0]),
    .wdata_i (life_in_q),
    .raddr_i (cur_q[PA-1:0]),
    .rdata_o (life_rd)
  );

  gppa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (p_q),
    .divisor_i  (lim_q),
    .done_o     (div_done),
    .quotient_o (quo),
    .ovf_o      (ovf)
  );

  // Control state: configuration, list heads, link valid bits, result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q    <= 1'b0;
      free_head_q <= '0;
      nvalid_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < GROUP_COUNT; i++) begin
        head_q[i] <= NULL_LINK;
      end
    end else begin
      if (cfg_we_i) begin
        paused_q <= cfg_wdata_i;
      end
      if (n_we) begin
        nvalid_q[n_waddr] <= 1'b1;
      end
      if (cmd_i.add_wr) begin
        head_q[g_q]  <= free_head_q;
        free_head_q  <= next_rd;
      end
      if (cmd_i.ent_upd && expired) begin
        free_head_q <= cur_q;
      end
      if (cmd_i.ent_unlink && !prev_link) begin
        head_q[g_q] <= nx_q;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rvalid_q <= nvalid_q[n_raddr];
    raddr_q  <= n_raddr;
    if (cmd_i.latch) begin
      tick_q    <= action_i;
      g_q       <= action_i ? '0 : grp_wrap(group_i);
      life_in_q <= lifespan_i;
      dt_q      <= time_step_i;
      slot_q    <= '0;
      cnt_q     <= '0;
    end
    if (cmd_i.add_wr) begin
      slot_q <= free_head_q[SLOT_W-1:0];
    end
    if (cmd_i.grp_load) begin
      cur_q  <= head_q[g_q];
      prev_q <= NULL_LINK;
    end
    if (cmd_i.grp_next) begin
      g_q <= g_q + GW'(1);
    end
    if (cmd_i.ent_a1) begin
      a1_q  <= a1_sum[AGE_W] ? '1 : a1_sum[AGE_W-1:0];
      lim_q <= life_rd;
      nx_q  <= next_rd;
    end
    if (cmd_i.ent_mul) begin
      p_q <= dt_q * a1_q;
    end
    if (cmd_i.ent_upd) begin
      if (expired) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        prev_q <= cur_q;
        cur_q  <= nx_q;
      end
    end
    if (cmd_i.ent_unlink) begin
      cur_q <= nx_q;
    end
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_slot_q   <= slot_q;
      out_count_q  <= cnt_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.paused   = paused_q;
  assign sts_o.is_tick  = tick_q;
  assign sts_o.free_ok  = free_head_q < LINK_W'(POOL_SIZE);
  assign sts_o.cur_link = cur_q < LINK_W'(POOL_SIZE);
  assign sts_o.last_grp = g_q == GW'(GROUP_COUNT - 1);
  assign sts_o.div_done = div_done;
  assign sts_o.expired  = expired;
  assign sts_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_count_o  = out_count_q;

endmodule

`default_nettype wire

// File: design/gppa_ctrl.sv
// Controller: sequences adds, list walks and per-entry aging over the datapath.
`timescale 1ns / 1ps
`default_nettype none

module gppa_ctrl
  import gppa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        if (sts_i.paused) state_d = S_DN_PAUSED;
        else if (sts_i.is_tick) state_d = S_GRP;
        else if (sts_i.free_ok) state_d = S_ADD_RD;
        else state_d = S_DN_FULL;
      end
      S_ADD_RD: state_d = S_ADD_WR;
      S_ADD_WR: state_d = S_DN_OK;
      S_GRP:    state_d = S_CHK;
      S_CHK: begin
        if (sts_i.cur_link) state_d = S_RD;
        else if (sts_i.last_grp) state_d = S_DN_OK;
        else state_d = S_GRP;
      end
      S_RD:    state_d = S_A1;
      S_A1:    state_d = S_MUL;
      S_MUL:   state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIV;
      S_DIV: begin
        if (sts_i.div_done) state_d = S_UPD;
      end
      S_UPD:    state_d = sts_i.expired ? S_UNLINK : S_CHK;
      S_UNLINK: state_d = S_CHK;
      S_DN_OK, S_DN_PAUSED, S_DN_FULL: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = RES_DONE;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_ADD_RD:  cmd_o.rd_free  = 1'b1;
      S_ADD_WR:  cmd_o.add_wr   = 1'b1;
      S_GRP:     cmd_o.grp_load = 1'b1;
      S_CHK:     cmd_o.grp_next = !sts_i.cur_link && !sts_i.last_grp;
      S_A1:      cmd_o.ent_a1   = 1'b1;
      S_MUL:     cmd_o.ent_mul  = 1'b1;
      S_DIVGO:   cmd_o.div_start = 1'b1;
      S_UPD:     cmd_o.ent_upd  = 1'b1;
      S_UNLINK:  cmd_o.ent_unlink = 1'b1;
      S_DN_OK: begin
        cmd_o.res_load = sts_i.out_free;
      end
      S_DN_PAUSED: begin
        cmd_o.res_load   = sts_i.out_free;
        cmd_o.res_status = RES_PAUSED;
      end
      S_DN_FULL: begin
        cmd_o.res_load   = sts_i.out_free;
        cmd_o.res_status = RES_FULL;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire
